// ----- src/sfk_pkg.sv -----
`default_nettype none

package sfk_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int IN_BITS        = 16;
    localparam int KERNEL_BITS    = 16;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take a new value, d = 2, k = 1
        logic div_start;  // set up a division of m (or of the last quotient) by d
        logic div_step;   // one restoring step
        logic apply;      // d divided m: m = quotient, flip odd
        logic mul_d;      // fold d into k if odd, move to next d
        logic mul_m;      // fold leftover prime into k
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sq_le;      // d*d <= m
        logic div_last;   // final restoring step this cycle
        logic rem_zero;   // last division left no remainder
    } t_stat;

endpackage

`default_nettype wire

// ----- src/sfk_dp.sv -----
`default_nettype none

module sfk_dp #(
    parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic [sfk_pkg::IN_BITS-1:0]    i_value,
    input  wire sfk_pkg::t_cmd                  i_cmd,
    output sfk_pkg::t_stat                      o_stat,
    output logic [sfk_pkg::KERNEL_BITS-1:0]     o_kernel,
    output logic                                o_is_perfect_square
);

    // d never passes floor(sqrt(m)) + 1
    localparam int DW = (VALUE_BITS + 1) / 2 + 1;
    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_m;
    logic [DW-1:0]         r_d;
    logic [VALUE_BITS-1:0] r_k;
    logic                  r_odd;
    logic [VALUE_BITS-1:0] r_quo;
    logic [DW-1:0]         r_rem;
    logic [CW-1:0]         r_cnt;

    logic [2*DW-1:0]            w_sq;
    logic [DW:0]                w_rem_sh;
    logic [DW:0]                w_diff;
    logic                       w_ge;
    logic [VALUE_BITS+DW-1:0]   w_kd;
    logic [2*VALUE_BITS-1:0]    w_km;

    assign w_sq     = r_d * r_d;
    assign w_rem_sh = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_d};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_kd     = r_k * r_d;
    assign w_km     = r_k * r_m;

    assign o_stat.sq_le    = w_sq <= (2*DW)'(r_m);
    assign o_stat.div_last = r_cnt == CW'(VALUE_BITS - 1);
    assign o_stat.rem_zero = r_rem == '0;

    assign o_kernel            = sfk_pkg::KERNEL_BITS'(r_k);
    assign o_is_perfect_square = r_k == VALUE_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m   <= VALUE_BITS'(i_value);
            r_d   <= DW'(2);
            r_k   <= VALUE_BITS'(1);
            r_odd <= 1'b0;
        end

        if (i_cmd.div_start) begin
            // after a clean division the quotient already sits in r_quo
            r_quo <= i_cmd.apply ? r_quo : r_m;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_cnt <= CW'(r_cnt + 1'b1);
        end

        if (i_cmd.apply) begin
            r_m   <= r_quo;
            r_odd <= ~r_odd;
        end

        if (i_cmd.mul_d) begin
            if (r_odd) begin
                r_k <= w_kd[VALUE_BITS-1:0];
            end
            r_d   <= DW'(r_d + 1'b1);
            r_odd <= 1'b0;
        end

        if (i_cmd.mul_m) begin
            if (r_m > VALUE_BITS'(1)) begin
                r_k <= w_km[VALUE_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sfk_ctrl.sv -----
`default_nettype none

module sfk_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire sfk_pkg::t_stat i_stat,
    output sfk_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_MULD  = 7'b0010000,
        S_MULM  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.sq_le) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_MULM;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // clean division: keep dividing by the same d
                if (i_stat.rem_zero) begin
                    o_cmd.apply     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_MULD;
                end
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_CHECK;
            end
            S_MULM: begin
                o_cmd.mul_m = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_state == S_DONE;

endmodule

`default_nettype wire

// ----- src/square_free_kernel.sv -----
`default_nettype none

// Square-free kernel by trial division. Pulse start while busy is low to hand
// over i_value; busy then stays high until the result beat, which appears on
// o_kernel / o_is_perfect_square for exactly one cycle with o_valid and must be
// captured then, though the outputs hold it until the next start. The time per
// item is data dependent and set by the restoring divider shared by all trial
// divisions: after the load, each tried d costs a check, a restoring division
// and evaluation per attempt and a step to the next d, with d running up to
// sqrt of what is left; the leftover fold and result beat end it. 0 to 3 try no d.
module square_free_kernel #(
    parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sfk_pkg::IN_BITS-1:0]       i_value,
    output logic                                   o_valid,
    output logic [sfk_pkg::KERNEL_BITS-1:0]        o_kernel,
    output logic                                   o_is_perfect_square
);

    sfk_pkg::t_cmd  w_cmd;
    sfk_pkg::t_stat w_stat;
    logic           w_busy;

    sfk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_valid (o_valid)
    );

    sfk_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_value             (i_value),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_kernel            (o_kernel),
        .o_is_perfect_square (o_is_perfect_square)
    );

    assign busy = w_busy;

endmodule

`default_nettype wire

// ----- src/sfk_checker.sv -----
`default_nettype none

module sfk_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_valid,
    input wire logic [sfk_pkg::KERNEL_BITS-1:0]   o_kernel,
    input wire logic                              o_is_perfect_square
);

    // accepted beat keeps the block busy from the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a busy window");

    // one result beat, then free for the next item
    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result beat not followed by idle");

    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_perfect_square == (o_kernel == sfk_pkg::KERNEL_BITS'(1))))
        else $error("perfect square flag disagrees with kernel");

    a_kernel_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kernel != '0))
        else $error("kernel of zero reported");

endmodule

bind square_free_kernel sfk_checker u_sfk_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_valid             (o_valid),
    .o_kernel            (o_kernel),
    .o_is_perfect_square (o_is_perfect_square)
);

`default_nettype wire
